// File: design/r2fft_pkg.sv
// r2fft_pkg: shared types, constants and twiddle-table functions for radix2_fft_512
// no dependencies
`default_nettype none

package r2fft_pkg;

    localparam int FFT_POINTS   = 512;
    localparam int FFT_LOG2     = 9;
    localparam int FFT_HALF     = FFT_POINTS / 2;
    localparam int FFT_QUARTER  = FFT_POINTS / 4;
    localparam int FFT_EIGHTH   = FFT_POINTS / 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int BANK_ADDR_W  = FFT_LOG2 + 1;
    localparam int STAGE_W      = 4;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518853;
    localparam longint unsigned Q30_ONE    = 64'd1 << 30;

    // ram write data source
    localparam logic [1:0] WSEL_SAMPLE = 2'd0;
    localparam logic [1:0] WSEL_UPPER  = 2'd1;
    localparam logic [1:0] WSEL_LOWER  = 2'd2;

    typedef logic [FFT_LOG2-1:0]    pos_t;
    typedef logic [FFT_LOG2-2:0]    widx_t;
    typedef logic [BANK_ADDR_W-1:0] baddr_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_re;
        logic signed [SAMPLE_WIDTH-1:0] sample_im;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] bin_re;
        logic signed [SAMPLE_WIDTH-1:0] bin_im;
        pos_t                           bin_index;
        logic                           bin_valid;
        logic                           frame_end;
    } out_t;

    typedef struct packed {
        logic       ram_we;
        logic [1:0] wr_sel;
        baddr_t     waddr;
        baddr_t     raddr;
        logic       cap_a;
        logic       mul_en;
        logic       sum_en;
        logic       out_load;
        pos_t       bin_index;
        logic       bin_valid;
        logic       frame_end;
        widx_t      widx;
    } cmd_t;

    function automatic pos_t fft_bitrev(input pos_t v);
        pos_t r;
        for (int i = 0; i < FFT_LOG2; i++)
        begin
            r[i] = v[FFT_LOG2-1-i];
        end
        return r;
    endfunction

    // unsigned shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned fft_udiv(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // cosine and sine of 2*pi*m/FFT_POINTS in q30, first octant, taylor series
    function automatic logic [127:0] fft_octant(input longint unsigned m);
        longint unsigned th;
        longint unsigned th2;
        longint unsigned tc;
        longint unsigned ts;
        longint          sc;
        longint          ss;
        th  = (TWO_PI_Q30 * m + longint'(FFT_HALF)) >> FFT_LOG2;
        th2 = (th * th) >> 30;
        tc  = Q30_ONE;
        ts  = th;
        sc  = longint'(tc);
        ss  = longint'(ts);
        for (int n = 1; n <= 7; n++)
        begin
            tc = fft_udiv((tc * th2) >> 30, longint'((2 * n - 1) * (2 * n)));
            ts = fft_udiv((ts * th2) >> 30, longint'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1)
            begin
                sc = sc - longint'(tc);
                ss = ss - longint'(ts);
            end
            else
            begin
                sc = sc + longint'(tc);
                ss = ss + longint'(ts);
            end
        end
        return {sc, ss};
    endfunction

    function automatic longint fft_q30_tw(input longint v, input int tw);
        int     s;
        longint maxv;
        longint x;
        longint r;
        s    = 31 - tw;
        maxv = (longint'(1) <<< (tw - 1)) - 1;
        x    = v;
        if (x < 0)
            x = 0;
        if (x > longint'(Q30_ONE))
            x = longint'(Q30_ONE);
        r = (x + (longint'(1) <<< (s - 1))) >>> s;
        return (r > maxv) ? maxv : r;
    endfunction

    // twiddle k as {re[23:0], im[23:0]}, two's complement q1.(tw-1)
    function automatic logic [47:0] fft_twiddle(input int k, input int tw);
        int           q;
        int           r;
        logic [127:0] cs;
        longint       c;
        longint       s;
        longint       cq;
        longint       sq;
        longint       wr;
        longint       wi;
        q = k >> (FFT_LOG2 - 2);
        r = k & (FFT_QUARTER - 1);
        if (r <= FFT_EIGHTH)
        begin
            cs = fft_octant(longint'(r));
            c  = cs[127:64];
            s  = cs[63:0];
        end
        else
        begin
            cs = fft_octant(longint'(FFT_QUARTER - r));
            s  = cs[127:64];
            c  = cs[63:0];
        end
        cq = fft_q30_tw(c, tw);
        sq = fft_q30_tw(s, tw);
        if (q == 0)
        begin
            wr = cq;
            wi = -sq;
        end
        else
        begin
            wr = -sq;
            wi = -cq;
        end
        return {wr[23:0], wi[23:0]};
    endfunction

endpackage

`default_nettype wire

// File: design/r2fft_ram.sv
// r2fft_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module r2fft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/r2fft_dp.sv
// r2fft_dp: datapath with frame ram, twiddle rom, butterfly unit and output register
// depends on r2fft_pkg and r2fft_ram
`default_nettype none

module r2fft_dp import r2fft_pkg::*; #(
    parameter int TWIDDLE_WIDTH = 16
) (
    input  wire logic clk,
    input  wire cmd_t cmd,
    input  wire in_t  in_data,
    output out_t      out_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = TWIDDLE_WIDTH;
    localparam int MW = SW + TW;
    localparam int PW = SW + TW + 2;
    localparam logic signed [PW-1:0] ONE  = PW'(longint'(1) <<< (TW - 1));
    localparam logic signed [PW-1:0] SMAX = PW'((longint'(1) <<< (SW - 1)) - 1);
    localparam logic signed [PW-1:0] SMIN = PW'(-(longint'(1) <<< (SW - 1)));

    // twiddle rom, constant table
    logic [TW-1:0] rom_re [FFT_HALF];
    logic [TW-1:0] rom_im [FFT_HALF];

    for (genvar k = 0; k < FFT_HALF; k++)
    begin : g_rom
        localparam logic [47:0] ENTRY = fft_twiddle(k, TW);
        assign rom_re[k] = ENTRY[24 +: TW];
        assign rom_im[k] = ENTRY[0 +: TW];
    end

    logic [2*SW-1:0] ram_wdata;
    logic [2*SW-1:0] ram_rdata;

    logic signed [SW-1:0] a_re_reg, a_im_reg;
    logic signed [MW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [SW-1:0] a2_re_reg, a2_im_reg;
    logic signed [SW-1:0] up_re_reg, up_im_reg, lo_re_reg, lo_im_reg;
    out_t                 out_reg;

    logic signed [SW-1:0] b_re, b_im;
    logic signed [TW-1:0] w_re, w_im;
    logic signed [PW-1:0] t_re, t_im, as_re, as_im;
    logic signed [PW-1:0] su_re, su_im, sl_re, sl_im;

    function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] y;
        y = x >>> TW;
        if (y > SMAX)
            return SW'(SMAX);
        else if (y < SMIN)
            return SW'(SMIN);
        else
            return y[SW-1:0];
    endfunction

    always_comb
    begin
        unique case (cmd.wr_sel)
            WSEL_UPPER: ram_wdata = {up_re_reg, up_im_reg};
            WSEL_LOWER: ram_wdata = {lo_re_reg, lo_im_reg};
            default:    ram_wdata = {in_data.sample_re, in_data.sample_im};
        endcase
    end

    r2fft_ram #(
        .WIDTH (2 * SW),
        .DEPTH (2 * FFT_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (cmd.waddr),
        .wdata (ram_wdata),
        .raddr (cmd.raddr),
        .rdata (ram_rdata)
    );

    assign b_re = ram_rdata[2*SW-1:SW];
    assign b_im = ram_rdata[SW-1:0];
    assign w_re = rom_re[cmd.widx];
    assign w_im = rom_im[cmd.widx];

    always_comb
    begin
        t_re  = PW'(p_rr_reg) - PW'(p_ii_reg);
        t_im  = PW'(p_ri_reg) + PW'(p_ir_reg);
        as_re = PW'(a2_re_reg) <<< (TW - 1);
        as_im = PW'(a2_im_reg) <<< (TW - 1);
        su_re = as_re + t_re + ONE;
        su_im = as_im + t_im + ONE;
        sl_re = as_re - t_re + ONE;
        sl_im = as_im - t_im + ONE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            a_re_reg <= b_re;
            a_im_reg <= b_im;
        end
        if (cmd.mul_en)
        begin
            p_rr_reg  <= b_re * w_re;
            p_ii_reg  <= b_im * w_im;
            p_ri_reg  <= b_re * w_im;
            p_ir_reg  <= b_im * w_re;
            a2_re_reg <= a_re_reg;
            a2_im_reg <= a_im_reg;
        end
        if (cmd.sum_en)
        begin
            up_re_reg <= sat(su_re);
            up_im_reg <= sat(su_im);
            lo_re_reg <= sat(sl_re);
            lo_im_reg <= sat(sl_im);
        end
        if (cmd.out_load)
        begin
            out_reg.bin_re    <= cmd.bin_valid ? b_re : '0;
            out_reg.bin_im    <= cmd.bin_valid ? b_im : '0;
            out_reg.bin_index <= cmd.bin_index;
            out_reg.bin_valid <= cmd.bin_valid;
            out_reg.frame_end <= cmd.frame_end;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: design/r2fft_ctrl.sv
// r2fft_ctrl: controller for loading, bin readout and the butterfly sequence
// depends on r2fft_pkg
`default_nettype none

module r2fft_ctrl import r2fft_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RESP = 3'd1;
    localparam logic [2:0] S_RA   = 3'd2;
    localparam logic [2:0] S_RB   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_WU   = 3'd6;
    localparam logic [2:0] S_WL   = 3'd7;

    localparam pos_t                 POS_LAST   = pos_t'(FFT_POINTS - 1);
    localparam widx_t                CNT_LAST   = widx_t'(FFT_HALF - 1);
    localparam logic [STAGE_W-1:0]   STAGE_LAST = STAGE_W'(FFT_LOG2 - 1);

    logic [2:0]         state_reg, state_next;
    pos_t               pos_reg, pos_next;
    logic               bank_reg, bank_next;
    logic               have_reg, have_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    widx_t              cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    logic  accept;
    widx_t span_mask, low, high;
    pos_t  addr_u, addr_l;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // butterfly addressing within the current stage
    always_comb
    begin
        span_mask = widx_t'((pos_t'(1) << stage_reg) - pos_t'(1));
        low       = cnt_reg & span_mask;
        high      = cnt_reg & ~span_mask;
        addr_u    = {high, 1'b0} | {1'b0, low};
        addr_l    = addr_u | (pos_t'(1) << stage_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        bank_next      = bank_reg;
        have_next      = have_reg;
        stage_next     = stage_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd           = '0;
        cmd.wr_sel    = WSEL_SAMPLE;
        cmd.raddr     = {bank_reg, addr_u};
        cmd.waddr     = {bank_reg, addr_u};
        cmd.bin_index = pos_reg;
        cmd.bin_valid = have_reg;
        cmd.frame_end = have_reg && (pos_reg == POS_LAST);
        cmd.widx      = widx_t'(low << (STAGE_LAST - stage_reg));

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.raddr = {~bank_reg, pos_reg};
                if (accept)
                begin
                    cmd.ram_we = 1'b1;
                    cmd.waddr  = {bank_reg, fft_bitrev(pos_reg)};
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                if (pos_reg == POS_LAST)
                begin
                    stage_next = '0;
                    cnt_next   = '0;
                    state_next = S_RA;
                end
                else
                begin
                    pos_next   = pos_reg + pos_t'(1);
                    state_next = S_IDLE;
                end
            end
            S_RA:
            begin
                state_next = S_RB;
            end
            S_RB:
            begin
                cmd.raddr  = {bank_reg, addr_l};
                cmd.cap_a  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_WU;
            end
            S_WU:
            begin
                cmd.ram_we = 1'b1;
                cmd.wr_sel = WSEL_UPPER;
                state_next = S_WL;
            end
            S_WL:
            begin
                cmd.ram_we = 1'b1;
                cmd.wr_sel = WSEL_LOWER;
                cmd.waddr  = {bank_reg, addr_l};
                cnt_next   = cnt_reg + widx_t'(1);
                state_next = S_RA;
                if (cnt_reg == CNT_LAST)
                begin
                    if (stage_reg == STAGE_LAST)
                    begin
                        bank_next  = ~bank_reg;
                        have_next  = 1'b1;
                        pos_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        stage_next = stage_reg + STAGE_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            bank_reg      <= 1'b0;
            have_reg      <= 1'b0;
            stage_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bank_reg      <= bank_next;
            have_reg      <= have_next;
            stage_reg     <= stage_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("input ready outside idle");

    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RESP))
        else $error("accepted sample not followed by response");

    a_resp_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) |=> out_valid_reg)
        else $error("response not presented");

    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WL) && (cnt_reg == CNT_LAST) && (stage_reg == STAGE_LAST))
        |=> (have_reg && (pos_reg == '0) && (bank_reg != $past(bank_reg))))
        else $error("frame completion did not swap banks");

endmodule

`default_nettype wire

// File: design/radix2_fft_512.sv
// radix2_fft_512: top level, 512-point radix-2 dit fft with double-buffered frames
// depends on r2fft_pkg, r2fft_ctrl, r2fft_dp (which uses r2fft_ram)
// the bin for an accepted sample is read from the other bank and presented through the output
//   register; a new sample is taken only once that bin has gone
// the last sample of a frame starts the transform: 9 stages x 256 butterflies, each stepping
//   through states ra, rb, mul, sum, wu and wl on one shared butterfly unit and one frame ram
// reset: async active low, clears control state; frame memory is not cleared
`default_nettype none

module radix2_fft_512 import r2fft_pkg::*; #(
    parameter int TWIDDLE_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // sample channel, one transaction per time-domain sample
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    // bin channel, one transaction per accepted sample
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    // command bundle from the sequencer to the datapath
    cmd_t cmd;

    // controller: load position, bank select, stage and butterfly counters
    r2fft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: two frame banks in one ram, twiddle rom, butterfly, output register
    r2fft_dp #(
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
